@@ hw/rtl/cgm_pkg.sv @@
package cgm_pkg;

    localparam int Q_W    = 32;
    localparam int MAG_W  = 31;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 64;
    localparam int RND_W  = PROD_W - FRAC_W;
    // index width of the lane addresses (up to eight entries)
    localparam int IDX_W  = 3;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sd32768;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_MAC   = 2'd1;
    localparam logic [1:0] OP_MUL_A = 2'd2;
    localparam logic [1:0] OP_MUL_B = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] addr;
        logic             acc_start;
        logic             wr_mixed;
        logic             wr_z;
    } lane_cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [Q_W-1:0]   data;
    } lane_wr_t;

    function automatic logic [MAG_W-1:0] abs31(input logic signed [Q_W-1:0] v);
        logic [Q_W-1:0] mag;
        begin
            mag = v[Q_W-1] ? (Q_W'(~v) + Q_W'(1)) : v;
            // the most negative value has no positive twin: clip it
            return mag[Q_W-1] ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/correlated_gaussian_max_abs.sv @@
// channel   signals                                      moves
// in        in_valid / in_ready + action..last_marker    load word or marker word
// out       out_valid / out_ready + max_abs              run maximum, one per last marker
//
// Load words are accepted back to back while idle. A marker word holds the input until
// its merge is done: each of the DIM lanes walks its matrix row through one multiplier,
// then, unless the marker opens a run, reuses it for a*Z and b*(L*n).
// Reset clears the state vector and the running maximum; the matrix has no reset.
// A waiting result does not block the input; only a further last marker waits
// for the output register to drain.
module correlated_gaussian_max_abs #(
    parameter int DIM = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [1:0]                      row,
    input  logic [1:0]                      col,
    input  logic signed [31:0]              matrix_value,
    input  logic signed [31:0]              a_coef,
    input  logic signed [31:0]              b_coef,
    input  logic signed [31:0]              noise_0,
    input  logic signed [31:0]              noise_1,
    input  logic signed [31:0]              noise_2,
    input  logic signed [31:0]              noise_3,
    input  logic                            first_marker,
    input  logic                            last_marker,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [30:0]                     max_abs
);
    import cgm_pkg::*;

    localparam int AW      = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int SW      = $clog2(DIM + 6);
    localparam int NOISE_N = 4;
    localparam logic [3:0] DIM_L = 4'(DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [SW-1:0]         step_reg;
    logic [SW-1:0]         step_next;
    logic                  first_reg;
    logic                  last_reg;
    logic signed [Q_W-1:0] a_reg;
    logic signed [Q_W-1:0] b_reg;
    logic signed [Q_W-1:0] noise_reg [DIM];
    logic signed [Q_W-1:0] noise_in [NOISE_N];
    logic signed [Q_W-1:0] noise_sel;
    logic signed [Q_W-1:0] z_vec [DIM];
    logic [SW-1:0]         end_step;
    logic                  take;
    logic                  take_marker;
    logic                  load_ok;
    logic                  mrg_go;
    lane_cmd_t             cmd;
    lane_wr_t              lane_wr [DIM];

    assign in_ready    = (state_reg == ST_IDLE);
    assign take        = in_valid && in_ready;
    assign take_marker = take && action;
    assign load_ok     = take && !action && ({2'b00, row} < DIM_L) && ({2'b00, col} < DIM_L);
    assign end_step    = first_reg ? SW'(DIM + 2) : SW'(DIM + 5);
    assign mrg_go      = (state_reg == ST_MERGE) && (!last_reg || !out_valid || out_ready);

    assign noise_in[0] = noise_0;
    assign noise_in[1] = noise_1;
    assign noise_in[2] = noise_2;
    assign noise_in[3] = noise_3;
    assign noise_sel   = noise_reg[step_reg[AW-1:0]];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_marker)
                begin
                    state_next = ST_CALC;
                    step_next  = '0;
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + SW'(1);
                if (step_reg == end_step - SW'(1))
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (mrg_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // issue schedule: DIM row products, then, unless the marker opens a run, a*Z, a bubble
    // for the mixed value to land, then b*(L*n); the tail steps drain the lane pipes
    always_comb
    begin
        cmd    = '0;
        cmd.op = OP_NONE;
        if (state_reg == ST_CALC)
        begin
            if (step_reg < SW'(DIM))
            begin
                cmd.op        = OP_MAC;
                cmd.addr      = IDX_W'(step_reg);
                cmd.acc_start = (step_reg == '0);
                cmd.wr_mixed  = (step_reg == SW'(DIM - 1));
                cmd.wr_z      = first_reg && (step_reg == SW'(DIM - 1));
            end
            else if (!first_reg && step_reg == SW'(DIM))
            begin
                cmd.op        = OP_MUL_A;
                cmd.acc_start = 1'b1;
            end
            else if (!first_reg && step_reg == SW'(DIM + 2))
            begin
                cmd.op   = OP_MUL_B;
                cmd.wr_z = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (take_marker)
            begin
                first_reg <= first_marker;
                last_reg  <= last_marker;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_marker)
        begin
            a_reg <= a_coef;
            b_reg <= b_coef;
        end
    end

    // samples beyond the four input ports read as zero
    for (genvar j = 0; j < DIM; j++)
    begin : g_noise
        if (j < NOISE_N)
        begin : g_port
            always_ff @(posedge clk)
            begin
                if (take_marker)
                begin
                    noise_reg[j] <= noise_in[j];
                end
            end
        end
        else
        begin : g_zero
            always_ff @(posedge clk)
            begin
                if (take_marker)
                begin
                    noise_reg[j] <= '0;
                end
            end
        end
    end

    for (genvar i = 0; i < DIM; i++)
    begin : g_lane
        assign lane_wr[i] = '{en:   load_ok && ({2'b00, row} == 4'(i)),
                              addr: IDX_W'(col),
                              data: matrix_value};

        cgm_lane #(
            .DIM(DIM)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .wr    (lane_wr[i]),
            .cmd   (cmd),
            .noise (noise_sel),
            .a_coef(a_reg),
            .b_coef(b_reg),
            .z     (z_vec[i])
        );
    end

    cgm_merge #(
        .DIM(DIM)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mrg_go),
        .first  (first_reg),
        .last   (last_reg),
        .z      (z_vec),
        .ready  (out_ready),
        .valid  (out_valid),
        .max_abs(max_abs)
    );

`ifndef NO_ASSERTIONS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        mrg_go && last_reg |-> !out_valid || out_ready)
        else $error("result overwrites a waiting word");

    a_marker_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        take_marker |=> !in_ready)
        else $error("input taken while a marker is in flight");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(mrg_go && last_reg))
        else $error("result raised without a last marker merge");

    a_first_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC && first_reg |-> cmd.op != OP_MUL_A && cmd.op != OP_MUL_B)
        else $error("state update issued on the opening marker");
`endif

endmodule

@@ hw/rtl/cgm_lane.sv @@
module cgm_lane #(
    parameter int DIM = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cgm_pkg::lane_wr_t                wr,
    input  cgm_pkg::lane_cmd_t               cmd,
    input  logic signed [cgm_pkg::Q_W-1:0]   noise,
    input  logic signed [cgm_pkg::Q_W-1:0]   a_coef,
    input  logic signed [cgm_pkg::Q_W-1:0]   b_coef,
    output logic signed [cgm_pkg::Q_W-1:0]   z
);
    import cgm_pkg::*;

    localparam int AW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ACC_W = RND_W + $clog2(DIM) + 1;

    logic [Q_W-1:0]           row_mem [DIM];
    logic signed [Q_W-1:0]    opx_reg;
    logic signed [Q_W-1:0]    opy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [Q_W-1:0]    mixed_reg;
    logic signed [Q_W-1:0]    z_reg;
    lane_cmd_t                cmd1_reg;
    lane_cmd_t                cmd2_reg;

    logic signed [PROD_W-1:0] biased;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-Q_W:0]       acc_hi;
    logic [Q_W-1:0]           sat_val;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            row_mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    // operand select; the matrix row read is registered here
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MAC:
            begin
                opx_reg <= row_mem[cmd.addr[AW-1:0]];
                opy_reg <= noise;
            end
            OP_MUL_A:
            begin
                opx_reg <= a_coef;
                opy_reg <= z_reg;
            end
            OP_MUL_B:
            begin
                opx_reg <= b_coef;
                opy_reg <= mixed_reg;
            end
            default:
            begin
                opx_reg <= '0;
                opy_reg <= '0;
            end
        endcase
        prod_reg <= PROD_W'(opx_reg) * PROD_W'(opy_reg);
    end

    // round half up: add half an LSB, then drop the fraction
    assign biased   = prod_reg + ROUND_BIAS;
    assign rnd      = {{(ACC_W-RND_W){biased[PROD_W-1]}}, biased[PROD_W-1:FRAC_W]};
    assign acc_next = (cmd2_reg.acc_start ? '0 : acc_reg) + rnd;
    assign acc_hi   = acc_next[ACC_W-1:Q_W-1];

    always_comb
    begin
        if (&acc_hi || ~|acc_hi)
        begin
            sat_val = acc_next[Q_W-1:0];
        end
        else
        begin
            sat_val = acc_next[ACC_W-1] ? Q_MIN : Q_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg <= '0;
            cmd2_reg <= '0;
            z_reg    <= '0;
        end
        else
        begin
            cmd1_reg <= cmd;
            cmd2_reg <= cmd1_reg;
            if (cmd2_reg.op != OP_NONE && cmd2_reg.wr_z)
            begin
                z_reg <= sat_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd2_reg.op != OP_NONE)
        begin
            acc_reg <= acc_next;
            if (cmd2_reg.wr_mixed)
            begin
                mixed_reg <= sat_val;
            end
        end
    end

    assign z = z_reg;

endmodule

@@ hw/rtl/cgm_merge.sv @@
module cgm_merge #(
    parameter int DIM = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic                             first,
    input  logic                             last,
    input  logic signed [cgm_pkg::Q_W-1:0]   z [DIM],
    input  logic                             ready,
    output logic                             valid,
    output logic [cgm_pkg::MAG_W-1:0]        max_abs
);
    import cgm_pkg::*;

    logic [MAG_W-1:0] run_max_reg;
    logic [MAG_W-1:0] run_max_next;
    logic             valid_reg;
    logic             valid_next;
    logic [MAG_W-1:0] max_abs_reg;

    always_comb
    begin
        logic [MAG_W-1:0] mag;
        run_max_next = first ? '0 : run_max_reg;
        for (int i = 0; i < DIM; i++)
        begin
            mag = abs31(z[i]);
            if (mag > run_max_next)
            begin
                run_max_next = mag;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg && !ready;
        if (go && last)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (go)
            begin
                run_max_reg <= run_max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && last)
        begin
            max_abs_reg <= run_max_next;
        end
    end

    assign valid   = valid_reg;
    assign max_abs = max_abs_reg;

endmodule

@@ tb/cgm_tb_pkg.sv @@
package cgm_tb_pkg;

    // matrix size the block is built with in this bench
    localparam int N_DIM = 4;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_MARKER = 1'b1
    } action_e;

endpackage

@@ tb/correlated_gaussian_max_abs_checker.sv @@
module correlated_gaussian_max_abs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               action,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] a_coef,
    input  logic signed [31:0] b_coef,
    input  logic signed [31:0] noise_0,
    input  logic signed [31:0] noise_1,
    input  logic signed [31:0] noise_2,
    input  logic signed [31:0] noise_3,
    input  logic               first_marker,
    input  logic               last_marker,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [30:0]        max_abs,
    output int                 fails,
    output int                 due
);
    timeunit 1ns;
    timeprecision 1ps;

    import cgm_pkg::*;
    import cgm_tb_pkg::*;

    logic signed [Q_W-1:0] mix_l [N_DIM][N_DIM] = '{default: '0};
    logic signed [Q_W-1:0] z_vec [N_DIM] = '{default: '0};
    logic [MAG_W-1:0]      peak = '0;
    logic [MAG_W-1:0]      max_abs_due [$];
    int                    n_bad = 0;
    int                    n_due = 0;

    assign fails = n_bad;
    assign due   = n_due;

    // Q16.16 product, round half up, kept wide
    function automatic logic signed [63:0] q_mul(input logic signed [Q_W-1:0] x,
                                                 input logic signed [Q_W-1:0] y);
        logic signed [63:0] xw;
        logic signed [63:0] yw;
        begin
            xw = 64'(x);
            yw = 64'(y);
            return (xw * yw + 64'sd32768) >>> FRAC_W;
        end
    endfunction

    function automatic logic signed [Q_W-1:0] q_sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[Q_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag31(input logic signed [Q_W-1:0] v);
        logic signed [Q_W:0] w;
        begin
            w = {v[Q_W-1], v};
            if (w < 0)
                w = -w;
            // minus full scale has no positive twin: clip
            if (w > 33'sd2147483647)
                return '1;
            return w[MAG_W-1:0];
        end
    endfunction

    task automatic take_marker();
        logic signed [Q_W-1:0] n [N_DIM];
        logic signed [Q_W-1:0] mixed;
        logic signed [63:0]    acc;
        begin
            n[0] = noise_0;
            n[1] = noise_1;
            n[2] = noise_2;
            n[3] = noise_3;
            if (first_marker)
                peak = '0;
            for (int i = 0; i < N_DIM; i++)
            begin
                acc = '0;
                for (int j = 0; j < N_DIM; j++)
                    acc += q_mul(mix_l[i][j], n[j]);
                mixed = q_sat(acc);
                if (first_marker)
                    z_vec[i] = mixed;
                else
                    z_vec[i] = q_sat(q_mul(a_coef, z_vec[i]) + q_mul(b_coef, mixed));
                if (mag31(z_vec[i]) > peak)
                    peak = mag31(z_vec[i]);
            end
            if (last_marker)
                max_abs_due.push_back(peak);
        end
    endtask

    always @(posedge clk)
    begin
        logic [MAG_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (max_abs_due.size() == 0)
                begin
                    $display("%0t: max_abs expected none, actual %h", $time, max_abs);
                    n_bad++;
                end
                else
                begin
                    want = max_abs_due.pop_front();
                    if (max_abs !== want)
                    begin
                        $display("%0t: max_abs expected %h, actual %h", $time, want, max_abs);
                        n_bad++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (action == ACT_LOAD)
                    mix_l[row][col] = matrix_value;
                else
                    take_marker();
            end
            n_due = max_abs_due.size();
        end
    end

endmodule

@@ tb/correlated_gaussian_max_abs_test.sv @@
module correlated_gaussian_max_abs_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cgm_pkg::*;
    import cgm_tb_pkg::*;

    localparam int ITEMS       = 800;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 20000;
    localparam int NOISE_SPAN  = 1 << 18;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] matrix_value;
    logic signed [31:0] a_coef;
    logic signed [31:0] b_coef;
    logic signed [31:0] noise_0;
    logic signed [31:0] noise_1;
    logic signed [31:0] noise_2;
    logic signed [31:0] noise_3;
    logic               first_marker;
    logic               last_marker;
    logic               out_valid;
    logic               out_ready;
    logic [30:0]        max_abs;

    int   n_fail;
    int   n_due;
    int   n_items;
    int   idle_cycles = 0;
    logic hold_req;
    logic steady;

    // mixes extremes, sign changes and zeros so every lane saturates somewhere
    logic signed [31:0] seed_l [16] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'shFFFF_0000,
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF,
        32'sh0001_0000, 32'sh0000_8000, 32'sh0000_0000, 32'sh7FFF_FFFF,
        32'shFFFF_8000, 32'sh0001_0000, 32'sh8000_0000, 32'sh0001_8000
    };

    correlated_gaussian_max_abs dut (.*);

    correlated_gaussian_max_abs_checker check (
        .*,
        .fails (n_fail),
        .due   (n_due)
    );

    initial
        clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [31:0] pick_q(input int span);
        int v;
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0: return Q_MAX;
                        1: return Q_MIN;
                        2: return '0;
                        default: return '1;
                    endcase
                end
                1: return $urandom;
                default:
                begin
                    v = int'($urandom_range(0, 2 * span)) - span;
                    return v;
                end
            endcase
        end
    endfunction

    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                return 0;
            if (r < 80)
                return $urandom_range(1, 3);
            if (r < 95)
                return $urandom_range(4, 12);
            return $urandom_range(30, 120);
        end
    endfunction

    task automatic put_word(input logic act, input logic [1:0] r, input logic [1:0] c,
                            input logic signed [31:0] mv, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic signed [31:0] n0,
                            input logic signed [31:0] n1, input logic signed [31:0] n2,
                            input logic signed [31:0] n3, input logic fm, input logic lm);
        int gap;
        begin
            action       <= act;
            row          <= r;
            col          <= c;
            matrix_value <= mv;
            a_coef       <= a;
            b_coef       <= b;
            noise_0      <= n0;
            noise_1      <= n1;
            noise_2      <= n2;
            noise_3      <= n3;
            first_marker <= fm;
            last_marker  <= lm;
            in_valid     <= 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
            n_items++;
            gap = steady ? 0 : idle_len();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // marker and coefficient fields are don't-care on a load: scramble them
    task automatic load_entry(input logic [1:0] r, input logic [1:0] c,
                              input logic signed [31:0] v);
        put_word(ACT_LOAD, r, c, v, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic mark(input logic signed [31:0] n0, input logic signed [31:0] n1,
                        input logic signed [31:0] n2, input logic signed [31:0] n3,
                        input logic signed [31:0] a, input logic signed [31:0] b,
                        input logic fm, input logic lm);
        put_word(ACT_MARKER, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                 a, b, n0, n1, n2, n3, fm, lm);
    endtask

    // mostly a decay below one and a modest gain, now and then anything
    task automatic noisy_mark(input logic fm, input logic lm);
        logic signed [31:0] a;
        logic signed [31:0] b;
        begin
            a = ($urandom_range(0, 7) == 0) ? pick_q(ONE) : $urandom_range(0, 65535);
            b = ($urandom_range(0, 7) == 0) ? pick_q(2 * ONE) : $urandom_range(0, 2 * ONE);
            mark(pick_q(NOISE_SPAN), pick_q(NOISE_SPAN), pick_q(NOISE_SPAN),
                 pick_q(NOISE_SPAN), a, b, fm, lm);
        end
    endtask

    initial
    begin
        int kind;
        int len;
        bit pressed;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_LOAD;
        row          = '0;
        col          = '0;
        matrix_value = '0;
        a_coef       = '0;
        b_coef       = '0;
        noise_0      = '0;
        noise_1      = '0;
        noise_2      = '0;
        noise_3      = '0;
        first_marker = 1'b0;
        last_marker  = 1'b0;
        hold_req     = 1'b0;
        steady       = 1'b0;
        n_items      = 0;
        pressed      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry goes in before any marker
        for (int i = 0; i < 16; i++)
            load_entry(2'(i / 4), 2'(i % 4), seed_l[i]);
        // marker with no run open: builds on the reset state
        mark(ONE, -ONE, ONE / 2, 2 * ONE, ONE, ONE, 1'b0, 1'b1);
        // single-marker runs at both ends of the noise range
        mark(Q_MAX, Q_MAX, Q_MAX, Q_MAX, ONE, ONE, 1'b1, 1'b1);
        mark(Q_MIN, Q_MIN, Q_MIN, Q_MIN, ONE, ONE, 1'b1, 1'b1);
        // run with saturating coefficients on both sides
        mark(ONE, ONE, -ONE, ONE, '0, '0, 1'b1, 1'b0);
        mark(Q_MAX, Q_MIN, ONE, -ONE, Q_MAX, Q_MAX, 1'b0, 1'b0);
        mark(Q_MIN, Q_MAX, -ONE, ONE, Q_MIN, Q_MIN, 1'b0, 1'b1);
        // zero noise then zero coefficients: the maximum must hold
        mark('0, '0, '0, '0, ONE, ONE, 1'b1, 1'b0);
        mark(ONE, ONE, ONE, ONE, '0, '0, 1'b0, 1'b1);

        // realistic matrix for the random runs
        for (int i = 0; i < 16; i++)
            load_entry(2'(i / 4), 2'(i % 4), pick_q(3 * ONE / 2));

        while (n_items < ITEMS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if (!pressed && n_items >= ITEMS / 2)
            begin
                // output held off while single-marker runs keep coming
                pressed  = 1'b1;
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (12) noisy_mark(1'b1, 1'b1);
                continue;
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 16))
                    load_entry(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               pick_q(3 * ONE / 2));
            end
            else if (kind == 1)
            begin
                repeat ($urandom_range(1, 6))
                    noisy_mark(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    noisy_mark(k == 0, k == len - 1);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (n_due != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

@@ correlated_gaussian_max_abs.f @@
hw/rtl/cgm_pkg.sv
hw/rtl/cgm_lane.sv
hw/rtl/cgm_merge.sv
hw/rtl/correlated_gaussian_max_abs.sv
tb/cgm_tb_pkg.sv
tb/correlated_gaussian_max_abs_checker.sv
tb/correlated_gaussian_max_abs_test.sv
